// File: rtl/mppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse packet tracker package
// Shared widths, reset values, register indexes and types for the tracker.
// ----------------------------------------------------------------------------
package mppt_pkg;

	localparam int POS_W     = 10;
	localparam int BYTE_W    = 8;
	localparam int REG_IDX_W = 1;

	// Bit positions inside the packet header byte.
	localparam int SYNC_BIT = 3;
	localparam int LEFT_BIT = 0;

	localparam logic [POS_W-1:0] RESET_X    = POS_W'(320);
	localparam logic [POS_W-1:0] RESET_Y    = POS_W'(200);
	localparam logic [POS_W-1:0] RESET_XLIM = POS_W'(624);
	localparam logic [POS_W-1:0] RESET_YLIM = POS_W'(464);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_X_LIMIT = 1'b0,
		REG_Y_LIMIT = 1'b1
	} reg_idx_t;

	// Which byte of the three-byte packet is expected next.
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_X_MOVE = 2'd1,
		PH_Y_MOVE = 2'd2
	} phase_t;

	typedef struct packed {
		logic [POS_W-1:0] x_limit;
		logic [POS_W-1:0] y_limit;
	} limits_t;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic             left_button;
		logic             moved;
	} result_t;

endpackage

// File: rtl/mppt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse packet tracker channels
// Valid/ready channels for received bytes and for position reports.
// ----------------------------------------------------------------------------
interface mppt_byte_if;
	import mppt_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              from_aux;

	modport source (output valid, output data_byte, output from_aux, input ready);
	modport sink   (input valid, input data_byte, input from_aux, output ready);
endinterface

interface mppt_report_if;
	import mppt_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] pos_x;
	logic [POS_W-1:0] pos_y;
	logic             left_button;
	logic             moved;

	modport source (output valid, output pos_x, output pos_y, output left_button,
		output moved, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input left_button,
		input moved, output ready);
endinterface

// File: rtl/mouse_packet_position_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse packet position tracker
// Decodes three-byte pointing-device packets into a clamped cursor position.
// ----------------------------------------------------------------------------
// Bytes arrive on the bytes channel, each tagged with whether it came from the
// auxiliary port. A packet starts only on an auxiliary byte with bit 3 set;
// any other byte in that position is dropped so the decoder can resynchronize.
// The next two bytes are taken as signed X and Y movement regardless of their
// port flag. On the third byte X movement is added and Y movement subtracted,
// each coordinate is clamped to zero and then to its limit register, and one
// report with the position, the left button and a moved flag is transferred
// on the reports channel. The block takes one byte per clock cycle: a byte is
// captured in an input register and decoded from there, and a finished report
// sits in an output register until the reports channel accepts it. The byte
// rate drops only while a finished report waits in the output register and
// another packet completes behind it. The limits are written through wr_en,
// wr_index and wr_data (index 0 is the X limit, index 1 the Y limit) and
// should only be changed while no byte or report is in flight. Position resets
// to (320, 200) and the limits to 624 and 464.
module mouse_packet_position_tracker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	mppt_byte_if.sink                      bytes,
	mppt_report_if.source                  reports,
	input  logic                           wr_en,
	input  logic [mppt_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [mppt_pkg::POS_W-1:0]     wr_data
);
	import mppt_pkg::*;

	limits_t           limits;
	result_t           core_res;
	result_t           res_q;
	logic              res_valid_q;
	logic              last_byte;
	logic              valid_s1;
	logic [BYTE_W-1:0] data_byte_s1;
	logic              from_aux_s1;
	logic              out_free;
	logic              advance_s1;
	logic              take_in;

	mppt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.limits   (limits)
	);

	mppt_packet_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.data_byte (data_byte_s1),
		.from_aux  (from_aux_s1),
		.limits    (limits),
		.last_byte (last_byte),
		.result    (core_res)
	);

	// The output register is free when empty or when its report transfers now.
	assign out_free   = !res_valid_q || reports.ready;
	// A byte that does not finish a packet always moves on.
	assign advance_s1 = valid_s1 && (!last_byte || out_free);
	assign bytes.ready = !valid_s1 || advance_s1;
	assign take_in    = bytes.valid && bytes.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_byte_s1 <= bytes.data_byte;
			from_aux_s1  <= bytes.from_aux;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && last_byte) begin
			res_valid_q <= 1'b1;
		end else if (reports.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_byte) begin
			res_q <= core_res;
		end
	end

	assign reports.valid       = res_valid_q;
	assign reports.pos_x       = res_q.pos_x;
	assign reports.pos_y       = res_q.pos_y;
	assign reports.left_button = res_q.left_button;
	assign reports.moved       = res_q.moved;

	// The input side stalls only while a byte is held in the input register.
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!bytes.ready |-> valid_s1)
		else $error("byte input stalled with an empty input register");

	// A new report appears only after the last byte of a packet was decoded.
	a_report_from_packet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(advance_s1 && last_byte))
		else $error("report raised without a completed packet");

	// A freshly loaded report lies within the limits it was computed against.
	a_report_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && last_byte) |=>
			(res_q.pos_x <= $past(limits.x_limit)) && (res_q.pos_y <= $past(limits.y_limit)))
		else $error("report position outside the limits");

endmodule

// File: rtl/mppt_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse packet tracker configuration registers
// Holds the horizontal and vertical position limits.
// ----------------------------------------------------------------------------
module mppt_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mppt_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [mppt_pkg::POS_W-1:0]       wr_data,
	output mppt_pkg::limits_t                limits
);
	import mppt_pkg::*;

	limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.x_limit <= RESET_XLIM;
			limits_q.y_limit <= RESET_YLIM;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_X_LIMIT: limits_q.x_limit <= wr_data;
				REG_Y_LIMIT: limits_q.y_limit <= wr_data;
				default: ;
			endcase
		end
	end

	assign limits = limits_q;

endmodule

// File: rtl/mppt_packet_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mouse packet tracker core
// Packet phase machine, cursor position registers and the clamped update.
// ----------------------------------------------------------------------------
module mppt_packet_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [mppt_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          from_aux,
	input  mppt_pkg::limits_t             limits,
	output logic                          last_byte,
	output mppt_pkg::result_t             result
);
	import mppt_pkg::*;

	phase_t            phase_q;
	phase_t            phase_nxt;
	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] x_move_q;
	logic [POS_W-1:0]  cur_x_q;
	logic [POS_W-1:0]  cur_y_q;
	logic signed [POS_W+1:0] sum_x;
	logic signed [POS_W+1:0] sum_y;
	logic [POS_W-1:0]  new_x;
	logic [POS_W-1:0]  new_y;
	logic              take_header;

	// Clamp to zero first, then to the limit.
	function automatic logic [POS_W-1:0] clamp_pos(input logic signed [POS_W+1:0] v,
		input logic [POS_W-1:0] lim);
		logic [POS_W-1:0] r;
		if (v[POS_W+1]) begin
			r = '0;
		end else if (v[POS_W:0] > {1'b0, lim}) begin
			r = lim;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

	assign sum_x = signed'({2'b00, cur_x_q})
		+ signed'({{(POS_W+2-BYTE_W){x_move_q[BYTE_W-1]}}, x_move_q});
	assign sum_y = signed'({2'b00, cur_y_q})
		- signed'({{(POS_W+2-BYTE_W){data_byte[BYTE_W-1]}}, data_byte});
	assign new_x = clamp_pos(sum_x, limits.x_limit);
	assign new_y = clamp_pos(sum_y, limits.y_limit);

	assign take_header = from_aux && data_byte[SYNC_BIT];

	// Next-state logic.
	always_comb begin
		unique case (phase_q)
			PH_X_MOVE: phase_nxt = PH_Y_MOVE;
			PH_Y_MOVE: phase_nxt = PH_HEADER;
			default:   phase_nxt = take_header ? PH_X_MOVE : PH_HEADER;
		endcase
	end

	// Output logic.
	always_comb begin
		last_byte          = (phase_q == PH_Y_MOVE);
		result.pos_x       = new_x;
		result.pos_y       = new_y;
		result.left_button = header_q[LEFT_BIT];
		result.moved       = (new_x != cur_x_q) || (new_y != cur_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			header_q <= '0;
			x_move_q <= '0;
			cur_x_q  <= RESET_X;
			cur_y_q  <= RESET_Y;
		end else if (step) begin
			phase_q <= phase_nxt;
			if (phase_q == PH_X_MOVE) begin
				x_move_q <= data_byte;
			end else if (phase_q == PH_Y_MOVE) begin
				cur_x_q <= new_x;
				cur_y_q <= new_y;
			end else if (take_header) begin
				header_q <= data_byte;
			end
		end
	end

endmodule
